FILE: rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Sequencer states, the product schedule and the index tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

    localparam int ADDR_W = 4;
    localparam int NUM_ELEMS = 9;

    localparam logic [4:0] DET_OP_FIRST = 5'd18;
    localparam logic [4:0] LAST_OP = 5'd20;
    localparam logic [3:0] LAST_K = 4'd8;
    localparam logic [1:0] IDX_LIMIT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_LD,
        ST_MUL,
        ST_DET_ABS,
        ST_DET_RND,
        ST_COF_ABS,
        ST_NUM_ADD,
        ST_DIV_CHK,
        ST_DIV,
        ST_EMIT,
        ST_EMIT_SING
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mcand_addr;
        logic [ADDR_W-1:0] mplier_addr;
        logic              use_cof;
        logic              neg;
        logic              clear;
        logic              save_cof;
    } op_t;

    function automatic logic [1:0] k_row(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] k_col(input logic [3:0] k);
        logic [1:0] c;
        unique case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_index(input logic [1:0] r,
                                                     input logic [1:0] c);
        return ADDR_W'(r) * ADDR_W'(3) + ADDR_W'(c);
    endfunction

    // Element (r,c) of the inverse takes cofactor (c,r).
    function automatic logic [ADDR_W-1:0] trans_index(input logic [3:0] k);
        return elem_index(k_col(k), k_row(k));
    endfunction

    // Schedule: two products for each of the nine cofactors, then the
    // expansion of the determinant along the first row.
    function automatic op_t op_info(input logic [4:0] op);
        op_t        info;
        logic [3:0] k;
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] ra;
        logic [1:0] rb;
        logic [1:0] ca;
        logic [1:0] cb;
        info = '0;
        k  = op[4:1];
        r  = k_row(k);
        c  = k_col(k);
        ra = (r == 2'd0) ? 2'd1 : 2'd0;
        rb = (r == 2'd2) ? 2'd1 : 2'd2;
        ca = (c == 2'd0) ? 2'd1 : 2'd0;
        cb = (c == 2'd2) ? 2'd1 : 2'd2;
        if (op >= DET_OP_FIRST)
        begin
            info.mcand_addr  = ADDR_W'(op - DET_OP_FIRST);
            info.mplier_addr = ADDR_W'(op - DET_OP_FIRST);
            info.use_cof     = 1'b1;
            info.clear       = (op == DET_OP_FIRST);
        end
        else if (op[0] == 1'b0)
        begin
            info.mcand_addr  = elem_index(ra, ca);
            info.mplier_addr = elem_index(rb, cb);
            info.neg         = k[0];
            info.clear       = 1'b1;
        end
        else
        begin
            info.mcand_addr  = elem_index(ra, cb);
            info.mplier_addr = elem_index(rb, ca);
            info.neg         = ~k[0];
            info.save_cof    = 1'b1;
        end
        return info;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mi3_alu.sv
// ----------------------------------------------------------------------------
// mi3_alu: shared adder and subtractor
// The one wide arithmetic unit; every product, quotient and rounding step
// passes through it.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_alu #(
    parameter int W = 99
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,
    output logic [W-1:0]      sum
);

    assign sum = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

FILE: rtl/mi3_store.sv
// ----------------------------------------------------------------------------
// mi3_store: element store of the 3x3 matrix
// Nine entries, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_store #(
    parameter int DW = 32
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [mi3_pkg::ADDR_W-1:0]    waddr,
    input  wire logic signed [DW-1:0]          wdata,
    input  wire logic [mi3_pkg::ADDR_W-1:0]    raddr,
    output logic signed [DW-1:0]               rdata
);

    logic signed [DW-1:0] mem [mi3_pkg::NUM_ELEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse: inverse of a 3x3 matrix in signed fixed point
// Elements load one a cycle while busy is low; a start request runs the adjugate and divide.
// ----------------------------------------------------------------------------
// A load on its own leaves busy low.
// A run computes 21 shift-add products on the shared adder, then takes the
// magnitude of the determinant and rounds it, then runs a restoring divide
// per element; a singular matrix emits nine flagged zero results instead.
// Results come out one at a time as each divide finishes; no stalls apply.
// Reset clears the sequencer and the result strobe; the store is not cleared.
`default_nettype none

module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] elem_value,
    input  wire logic [1:0]         elem_row,
    input  wire logic [1:0]         elem_col,
    input  wire logic               start_req,
    output logic                    result_valid,
    output logic signed [31:0]      inv_value,
    output logic [1:0]              out_row,
    output logic [1:0]              out_col,
    output logic signed [31:0]      det_value,
    output logic                    singular,
    output logic                    overflow,
    output logic                    last
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int CW = 2 * DW + 1;
    localparam int AW_A = 3 * DW + 3;
    localparam int AW_B = 2 * DW + 2 * FB + 3;
    localparam int AW = (AW_A > AW_B) ? AW_A : AW_B;
    localparam int BW = $clog2(DW);
    localparam logic [BW-1:0] BIT_LAST = BW'(DW - 1);
    localparam logic [AW-1:0] DET_HALF = AW'(1) << (2 * FB - 1);
    localparam logic [AW-1:0] LIM_POS = (AW'(1) << (DW - 1)) - AW'(1);
    localparam logic [AW-1:0] LIM_NEG = AW'(1) << (DW - 1);
    localparam logic [DW-1:0] Q_LIM_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] Q_LIM_NEG = {1'b1, {(DW-1){1'b0}}};

    mi3_pkg::state_t state_reg, state_next;
    logic [4:0]      op_reg;
    logic [BW-1:0]   bit_reg;
    logic [3:0]      k_reg;
    mi3_pkg::op_t    op_cur;

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] mcand_reg;
    logic [DW-1:0]        mplier_reg;
    logic signed [CW-1:0] cof_reg [mi3_pkg::NUM_ELEMS];
    logic                 det_neg_reg;
    logic [AW-1:0]        det_mag_reg;
    logic                 sing_reg;
    logic signed [DW-1:0] det_field_reg;
    logic                 det_ov_reg;
    logic [AW-1:0]        work_reg;
    logic [DW-1:0]        low_reg;
    logic [DW-1:0]        quo_reg;
    logic                 qneg_reg;
    logic                 sat_reg;

    logic                          accept;
    logic                          wr_en;
    logic [mi3_pkg::ADDR_W-1:0]    rd_addr;
    logic signed [DW-1:0]          mem_q;
    logic [AW-1:0]                 alu_a, alu_b, alu_sum;
    logic                          alu_sub;
    logic                          bit_last;
    logic signed [CW-1:0]          cof_sel;
    logic [AW-1:0]                 det_rnd;
    logic                          det_sat;
    logic                          q_nz, q_neg, q_over;
    logic signed [DW-1:0]          q_val;

    assign busy     = (state_reg != mi3_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign wr_en    = accept && (elem_row != mi3_pkg::IDX_LIMIT)
                      && (elem_col != mi3_pkg::IDX_LIMIT);
    assign op_cur   = mi3_pkg::op_info(op_reg);
    assign bit_last = (bit_reg == BIT_LAST);
    assign cof_sel  = cof_reg[mi3_pkg::trans_index(k_reg)];

    mi3_store #(
        .DW(DW)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (mi3_pkg::elem_index(elem_row, elem_col)),
        .wdata (DW'(elem_value)),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    mi3_alu #(
        .W(AW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // Determinant rounding and saturation, ties away from zero.
    assign det_rnd = alu_sum >> (2 * FB);
    assign det_sat = det_neg_reg ? (det_rnd > LIM_NEG) : (det_rnd > LIM_POS);

    // Quotient sign and saturation.
    assign q_nz   = sat_reg || (quo_reg != '0);
    assign q_neg  = (qneg_reg != det_neg_reg) && q_nz;
    assign q_over = sat_reg || (q_neg ? (quo_reg > Q_LIM_NEG) : (quo_reg > Q_LIM_POS));
    always_comb
    begin
        if (q_over)
        begin
            q_val = q_neg ? $signed(Q_LIM_NEG) : $signed(Q_LIM_POS);
        end
        else
        begin
            q_val = q_neg ? -$signed(quo_reg) : $signed(quo_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mi3_pkg::ST_IDLE:
            begin
                if (accept && start_req)
                begin
                    state_next = mi3_pkg::ST_RD_A;
                end
            end
            mi3_pkg::ST_RD_A:    state_next = mi3_pkg::ST_RD_B;
            mi3_pkg::ST_RD_B:    state_next = mi3_pkg::ST_MUL_LD;
            mi3_pkg::ST_MUL_LD:  state_next = mi3_pkg::ST_MUL;
            mi3_pkg::ST_MUL:
            begin
                if (bit_last)
                begin
                    state_next = (op_reg == mi3_pkg::LAST_OP) ? mi3_pkg::ST_DET_ABS
                                                              : mi3_pkg::ST_RD_A;
                end
            end
            mi3_pkg::ST_DET_ABS: state_next = mi3_pkg::ST_DET_RND;
            mi3_pkg::ST_DET_RND:
            begin
                state_next = sing_reg ? mi3_pkg::ST_EMIT_SING : mi3_pkg::ST_COF_ABS;
            end
            mi3_pkg::ST_COF_ABS: state_next = mi3_pkg::ST_NUM_ADD;
            mi3_pkg::ST_NUM_ADD: state_next = mi3_pkg::ST_DIV_CHK;
            mi3_pkg::ST_DIV_CHK:
            begin
                state_next = alu_sum[AW-1] ? mi3_pkg::ST_DIV : mi3_pkg::ST_EMIT;
            end
            mi3_pkg::ST_DIV:
            begin
                if (bit_last)
                begin
                    state_next = mi3_pkg::ST_EMIT;
                end
            end
            mi3_pkg::ST_EMIT:
            begin
                state_next = (k_reg == mi3_pkg::LAST_K) ? mi3_pkg::ST_IDLE
                                                        : mi3_pkg::ST_COF_ABS;
            end
            mi3_pkg::ST_EMIT_SING:
            begin
                if (k_reg == mi3_pkg::LAST_K)
                begin
                    state_next = mi3_pkg::ST_IDLE;
                end
            end
            default:             state_next = mi3_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared adder and the store read address.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        rd_addr = op_cur.mplier_addr;
        unique case (state_reg)
            mi3_pkg::ST_RD_A:
            begin
                rd_addr = op_cur.mcand_addr;
            end
            mi3_pkg::ST_MUL:
            begin
                // The top bit of a two's complement multiplier weighs negative.
                alu_a   = acc_reg;
                alu_b   = mplier_reg[0] ? mcand_reg : '0;
                alu_sub = op_cur.neg ^ bit_last;
            end
            mi3_pkg::ST_DET_ABS:
            begin
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            mi3_pkg::ST_DET_RND:
            begin
                alu_a = det_mag_reg;
                alu_b = DET_HALF;
            end
            mi3_pkg::ST_COF_ABS:
            begin
                alu_b   = AW'(cof_sel);
                alu_sub = 1'b1;
            end
            mi3_pkg::ST_NUM_ADD:
            begin
                alu_a = work_reg << (2 * FB + 1);
                alu_b = det_mag_reg;
            end
            mi3_pkg::ST_DIV_CHK:
            begin
                alu_a   = work_reg >> DW;
                alu_b   = det_mag_reg << 1;
                alu_sub = 1'b1;
            end
            mi3_pkg::ST_DIV:
            begin
                alu_a   = {work_reg[AW-2:0], low_reg[DW-1]};
                alu_b   = det_mag_reg << 1;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer counters and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mi3_pkg::ST_IDLE;
            op_reg       <= '0;
            bit_reg      <= '0;
            k_reg        <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == mi3_pkg::ST_EMIT)
                            || (state_reg == mi3_pkg::ST_EMIT_SING);
            unique case (state_reg)
                mi3_pkg::ST_IDLE:
                begin
                    op_reg <= '0;
                end
                mi3_pkg::ST_MUL_LD:
                begin
                    bit_reg <= '0;
                end
                mi3_pkg::ST_MUL:
                begin
                    bit_reg <= bit_reg + BW'(1);
                    if (bit_last)
                    begin
                        op_reg <= op_reg + 5'd1;
                    end
                end
                mi3_pkg::ST_DET_RND:
                begin
                    k_reg <= '0;
                end
                mi3_pkg::ST_DIV_CHK:
                begin
                    bit_reg <= '0;
                end
                mi3_pkg::ST_DIV:
                begin
                    bit_reg <= bit_reg + BW'(1);
                end
                mi3_pkg::ST_EMIT, mi3_pkg::ST_EMIT_SING:
                begin
                    k_reg <= k_reg + 4'd1;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mi3_pkg::ST_RD_B:
            begin
                mcand_reg <= op_cur.use_cof ? AW'(cof_reg[op_cur.mcand_addr])
                                            : AW'(mem_q);
            end
            mi3_pkg::ST_MUL_LD:
            begin
                mplier_reg <= mem_q;
                if (op_cur.clear)
                begin
                    acc_reg <= '0;
                end
            end
            mi3_pkg::ST_MUL:
            begin
                acc_reg    <= alu_sum;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                if (bit_last && op_cur.save_cof)
                begin
                    cof_reg[op_reg[4:1]] <= CW'(alu_sum);
                end
            end
            mi3_pkg::ST_DET_ABS:
            begin
                det_neg_reg <= acc_reg[AW-1];
                det_mag_reg <= acc_reg[AW-1] ? alu_sum : acc_reg;
                sing_reg    <= (acc_reg == '0);
            end
            mi3_pkg::ST_DET_RND:
            begin
                det_ov_reg <= !sing_reg && det_sat;
                if (sing_reg)
                begin
                    det_field_reg <= '0;
                end
                else if (det_sat)
                begin
                    det_field_reg <= det_neg_reg ? $signed(Q_LIM_NEG) : $signed(Q_LIM_POS);
                end
                else
                begin
                    det_field_reg <= det_neg_reg ? -$signed(det_rnd[DW-1:0])
                                                 : $signed(det_rnd[DW-1:0]);
                end
            end
            mi3_pkg::ST_COF_ABS:
            begin
                qneg_reg <= cof_sel[CW-1];
                work_reg <= cof_sel[CW-1] ? alu_sum : AW'(cof_sel);
            end
            mi3_pkg::ST_NUM_ADD:
            begin
                work_reg <= alu_sum;
            end
            mi3_pkg::ST_DIV_CHK:
            begin
                // A quotient of 2^DW or more saturates whatever its sign.
                sat_reg  <= !alu_sum[AW-1];
                work_reg <= work_reg >> DW;
                low_reg  <= work_reg[DW-1:0];
                quo_reg  <= '0;
            end
            mi3_pkg::ST_DIV:
            begin
                work_reg <= alu_sum[AW-1] ? alu_a : alu_sum;
                quo_reg  <= {quo_reg[DW-2:0], !alu_sum[AW-1]};
                low_reg  <= low_reg << 1;
            end
            mi3_pkg::ST_EMIT:
            begin
                inv_value <= 32'(q_val);
                out_row   <= mi3_pkg::k_row(k_reg);
                out_col   <= mi3_pkg::k_col(k_reg);
                det_value <= 32'(det_field_reg);
                singular  <= 1'b0;
                overflow  <= q_over || det_ov_reg;
                last      <= (k_reg == mi3_pkg::LAST_K);
            end
            mi3_pkg::ST_EMIT_SING:
            begin
                inv_value <= '0;
                out_row   <= mi3_pkg::k_row(k_reg);
                out_col   <= mi3_pkg::k_col(k_reg);
                det_value <= '0;
                singular  <= 1'b1;
                overflow  <= 1'b0;
                last      <= (k_reg == mi3_pkg::LAST_K);
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: dv/inverse_checker.sv
// ----------------------------------------------------------------------------
// inverse_checker: predictor and scoreboard for the 3x3 matrix inverse
// Watches element transfers, keeps its own copy of the matrix, predicts the
// nine inverse results of every start request and compares them in order.
// ----------------------------------------------------------------------------
module inverse_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] elem_value,
    input  logic [1:0]         elem_row,
    input  logic [1:0]         elem_col,
    input  logic               start_req,
    input  logic               result_valid,
    input  logic signed [31:0] inv_value,
    input  logic [1:0]         out_row,
    input  logic [1:0]         out_col,
    input  logic signed [31:0] det_value,
    input  logic               singular,
    input  logic               overflow,
    input  logic               last,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] det;
        logic        sing;
        logic        ovf;
        logic        lst;
    } inv_elem_t;

    logic [31:0] shadow_matrix [9];
    inv_elem_t   expected_inv [$];

    initial
    begin
        errors = 0;
        foreach (shadow_matrix[i])
            shadow_matrix[i] = '0;
    end

    assign pending = expected_inv.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Clamps a magnitude to the signed 32-bit range; sets ovf on saturation.
    function automatic logic [31:0] saturate32(input logic [127:0] mag, input logic neg,
                                               inout logic ovf);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = mag;
        if (m > lim)
        begin
            ovf = 1'b1;
            m = lim;
        end
        return neg ? 32'(-m) : 32'(m);
    endfunction

    task automatic predict_inverse();
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0]        det_mag;
        logic [127:0]        num;
        logic [127:0]        quo;
        logic [31:0]         det_field;
        logic                det_ovf;
        logic                is_sing;
        logic                ovf;
        inv_elem_t           res;
        int                  ra, rb, ca, cb;
        foreach (e[i])
            e[i] = 128'(signed'(shadow_matrix[i]));
        det = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[2] * e[3] * e[7]
            - e[0] * e[5] * e[7] - e[1] * e[3] * e[8] - e[2] * e[4] * e[6];
        for (int r = 0; r < 3; r++)
        begin
            ra = (r == 0) ? 1 : 0;
            rb = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++)
            begin
                ca = (c == 0) ? 1 : 0;
                cb = (c == 2) ? 1 : 2;
                cof[r * 3 + c] = e[ra * 3 + ca] * e[rb * 3 + cb]
                               - e[ra * 3 + cb] * e[rb * 3 + ca];
                if ((r + c) % 2 == 1)
                    cof[r * 3 + c] = -cof[r * 3 + c];
            end
        end
        is_sing = (det == 0);
        det_mag = (det < 0) ? 128'(-det) : 128'(det);
        det_ovf = 1'b0;
        det_field = '0;
        if (!is_sing)
            det_field = saturate32((det_mag + (128'd1 << 31)) >> 32, det < 0, det_ovf);
        for (int k = 0; k < 9; k++)
        begin
            ovf = det_ovf;
            res.value = '0;
            if (!is_sing)
            begin
                // Rounded quotient: (2|cof| * 2^32 + |det|) / (2|det|).
                num = cof[(k % 3) * 3 + k / 3] < 0 ? 128'(-cof[(k % 3) * 3 + k / 3])
                                                   : 128'(cof[(k % 3) * 3 + k / 3]);
                num = (num << 33) + det_mag;
                quo = num / (det_mag << 1);
                res.value = saturate32(quo,
                    ((cof[(k % 3) * 3 + k / 3] < 0) != (det < 0)) && (quo != 0), ovf);
            end
            res.row  = 2'(k / 3);
            res.col  = 2'(k % 3);
            res.det  = det_field;
            res.sing = is_sing;
            res.ovf  = ovf;
            res.lst  = (k == 8);
            expected_inv.push_back(res);
        end
    endtask

    always @(posedge clk)
    begin
        inv_elem_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_inv.size() == 0)
                    report_mismatch("inverse element with nothing expected");
                else
                begin
                    want = expected_inv.pop_front();
                    if (inv_value !== want.value)
                        report_mismatch($sformatf("inv_value %h, want %h", inv_value,
                                                  want.value));
                    if (out_row !== want.row || out_col !== want.col)
                        report_mismatch($sformatf("position %0d,%0d, want %0d,%0d",
                                                  out_row, out_col, want.row, want.col));
                    if (det_value !== want.det)
                        report_mismatch($sformatf("det_value %h, want %h", det_value,
                                                  want.det));
                    if (singular !== want.sing)
                        report_mismatch($sformatf("singular %b, want %b", singular,
                                                  want.sing));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b", overflow,
                                                  want.ovf));
                    if (last !== want.lst)
                        report_mismatch($sformatf("last %b, want %b", last, want.lst));
                end
            end
            if (start && !busy)
            begin
                if (elem_row < 2'd3 && elem_col < 2'd3)
                    shadow_matrix[elem_row * 3 + elem_col] = elem_value;
                if (start_req)
                    predict_inverse();
            end
        end
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the 3x3 matrix inverse
// Directed matrices (identity, singular, extremes, tiny determinant, ignored
// writes) and then random load sequences with random gaps; the checker
// predicts and compares every inverse element.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_ITEMS = 260;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] elem_value = '0;
    logic [1:0]         elem_row = '0;
    logic [1:0]         elem_col = '0;
    logic               start_req = 1'b0;
    logic               result_valid;
    logic signed [31:0] inv_value;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] det_value;
    logic               singular;
    logic               overflow;
    logic               last;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;
    logic               no_gaps = 1'b0;

    always #5 clk = ~clk;

    matrix3x3_inverse u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem_value(elem_value), .elem_row(elem_row), .elem_col(elem_col),
        .start_req(start_req), .result_valid(result_valid), .inv_value(inv_value),
        .out_row(out_row), .out_col(out_col), .det_value(det_value),
        .singular(singular), .overflow(overflow), .last(last)
    );

    inverse_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem_value(elem_value), .elem_row(elem_row), .elem_col(elem_col),
        .start_req(start_req), .result_valid(result_valid), .inv_value(inv_value),
        .out_row(out_row), .out_col(out_col), .det_value(det_value),
        .singular(singular), .overflow(overflow), .last(last),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic load_elem(input logic [31:0] v, input logic [1:0] r,
                             input logic [1:0] c, input logic go);
        if (!no_gaps && $urandom_range(0, 99) < 14)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        elem_value = v;
        elem_row   = r;
        elem_col   = c;
        start_req  = go;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            2: v = 32'(int'($urandom_range(0, 2)) - 1) * ONE;
            3: v = 32'(int'($urandom_range(0, 6)) - 3) * ONE;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = '0;
                    3: v = 32'hffff_ffff;
                    default: v = 32'd1;
                endcase
            end
            default: v = 32'($urandom_range(0, 255)) - 32'd128;
        endcase
        return v;
    endfunction

    initial
    begin
        int done_items;
        int n;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Identity fills every element before the first computation.
        for (int k = 0; k < 9; k++)
            load_elem((k % 4 == 0) ? ONE : 32'd0, 2'(k / 3), 2'(k % 3), k == 8);
        load_elem(32'd0, 2'd0, 2'd0, 1'b1);                 // singular
        load_elem(32'h7fff_ffff, 2'd0, 2'd0, 1'b1);         // large determinant
        load_elem(32'h8000_0000, 2'd1, 2'd1, 1'b1);         // most negative
        load_elem(32'h1234_5678, 2'd3, 2'd1, 1'b1);         // ignored write
        load_elem(32'h5555_5555, 2'd2, 2'd3, 1'b0);
        load_elem(32'd1, 2'd0, 2'd0, 1'b0);                 // tiny determinant
        load_elem(32'd1, 2'd1, 2'd1, 1'b0);
        load_elem(32'd1, 2'd2, 2'd2, 1'b1);
        load_elem(32'hffff_ffff, 2'd0, 2'd2, 1'b0);
        load_elem(32'h8000_0000, 2'd2, 2'd0, 1'b1);
        load_elem(32'haaaa_aaaa, 2'd3, 2'd3, 1'b1);

        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            no_gaps = (done_items >= 100 && done_items < 160);
            if ($urandom_range(0, 99) < 85)
            begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    load_elem(pick_value(), 2'($urandom_range(0, 2)),
                              2'($urandom_range(0, 2)), i == n - 1);
                done_items += n;
            end
            else
            begin
                load_elem(pick_value(), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
                done_items++;
            end
        end
        start = 1'b0;
        start_req = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
